### hdl/mbrtu_pkg.sv
// ----------------------------------------------------------------------------
// mbrtu_pkg
// Shared types, constants and the CRC-16 byte step for the Modbus RTU engine.
// ----------------------------------------------------------------------------
`default_nettype none
package mbrtu_pkg;

  localparam int FRAME_BYTES = 128;
  localparam int REG_COUNT   = 32;

  localparam int AW  = $clog2(FRAME_BYTES);
  localparam int CW  = $clog2(FRAME_BYTES + 1);
  localparam int RIW = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;

  localparam logic [15:0] CRC_POLY = 16'hA001;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [7:0]  EXC_FLAG = 8'h80;

  localparam logic [2:0] MODE_RX   = 3'd0;
  localparam logic [2:0] MODE_GAP  = 3'd1;
  localparam logic [2:0] MODE_TX   = 3'd2;
  localparam logic [2:0] MODE_HRD  = 3'd3;
  localparam logic [2:0] MODE_HWR  = 3'd4;

  localparam logic [1:0] KIND_TX      = 2'd0;
  localparam logic [1:0] KIND_HOST    = 2'd1;
  localparam logic [1:0] KIND_VERDICT = 2'd2;

  localparam logic [1:0] VD_IGNORED = 2'd0;
  localparam logic [1:0] VD_REPLY   = 2'd1;
  localparam logic [1:0] VD_BCAST   = 2'd2;
  localparam logic [1:0] VD_ERROR   = 2'd3;

  localparam logic [7:0] FN_READ  = 8'd3;
  localparam logic [7:0] FN_WR1   = 8'd6;
  localparam logic [7:0] FN_WRN   = 8'd16;

  localparam logic [7:0] EXC_FUNC = 8'd1;
  localparam logic [7:0] EXC_ADDR = 8'd2;
  localparam logic [7:0] EXC_DATA = 8'd3;

  localparam logic       CFG_SLAVE = 1'b0;
  localparam logic       CFG_INUSE = 1'b1;

  typedef enum logic [1:0] {
    RT_EXC  = 2'd0,
    RT_READ = 2'd1,
    RT_ECHO = 2'd2
  } rtype_t;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_TXRD  = 7'b0000010,
    S_SCAN  = 7'b0000100,
    S_CHECK = 7'b0001000,
    S_COPY  = 7'b0010000,
    S_REPLY = 7'b0100000,
    S_EMIT  = 7'b1000000
  } state_t;

  function automatic logic [15:0] crc16_byte(input logic [15:0] c_in, input logic [7:0] b);
    logic [15:0] c;
    c = c_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) c = (c >> 1) ^ CRC_POLY;
      else      c = c >> 1;
    end
    return c;
  endfunction

endpackage
`default_nettype wire

### hdl/modbus_rtu_slave_frame_engine.sv
// ----------------------------------------------------------------------------
// modbus_rtu_slave_frame_engine
// Modbus RTU slave: frame buffer, CRC check, functions 3/6/16, reply staging.
// ----------------------------------------------------------------------------
// One word is taken at a time. Line bytes, host writes and empty transmit
// slots are handled in the idle state; a host read passes through the result
// stage, and a transmit slot with a byte reads the frame buffer before it.
// A frame gap walks the frame buffer once through the byte-wide CRC unit, a
// function 16 frame then walks its data bytes again, and a staged reply is
// written one byte per cycle through the same CRC unit.
// Results wait in an output register, and a word that gives no result is taken
// meanwhile; a word with a result holds the input off while the output stalls.
`default_nettype none
module modbus_rtu_slave_frame_engine (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // rx_byte[7:0], reg_index[12:8], reg_value[28:13]
  input  wire logic [2:0]  in_tuser,   // mode
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [63:0]      out_tdata,  // tx_byte[7:0], read_value[23:8], verdict[25:24],
                                       // error_total[41:26], reads_served[57:42]
  output logic             out_tlast,  // tx_last
  output logic [1:0]       out_tuser,  // kind
  input  wire logic        cfg_wr_en,
  input  wire logic        cfg_index,
  input  wire logic [7:0]  cfg_wdata
);

  localparam int AW  = mbrtu_pkg::AW;
  localparam int CW  = mbrtu_pkg::CW;
  localparam int RIW = mbrtu_pkg::RIW;

  mbrtu_pkg::state_t state_r, state_nxt;
  mbrtu_pkg::rtype_t rtype_r, rtype_nxt;

  logic [7:0]  mem [mbrtu_pkg::FRAME_BYTES];
  logic [7:0]  rdata_r;
  logic        mem_we;
  logic [AW-1:0] mem_wa, mem_ra;
  logic [7:0]  mem_wd;

  logic [15:0] hr_r [mbrtu_pkg::REG_COUNT];
  logic        hr_we;
  logic [RIW-1:0] hr_wa, hr_ra;
  logic [15:0] hr_wd, hr_rd;

  logic [CW-1:0] byte_cnt_r, byte_cnt_nxt, nlen_r, nlen_nxt;
  logic [CW-1:0] rep_len_r, rep_len_nxt, rep_pos_r, rep_pos_nxt;
  logic [CW-1:0] ptr_r, ptr_nxt, ridx_r, ridx_nxt, pos_r, pos_nxt, len_r, len_nxt;
  logic        ovf_r, ovf_nxt, rv_vld_r, rv_vld_nxt;
  logic [15:0] err_cnt_r, err_cnt_nxt, rd_cnt_r, rd_cnt_nxt;
  logic [7:0]  slave_r, slave_nxt;
  logic [5:0]  riu_r, riu_nxt;
  logic [7:0]  addr_r, addr_nxt, fn_r, fn_nxt, bc6_r, bc6_nxt;
  logic [7:0]  crc_lo_r, crc_lo_nxt, crc_hi_r, crc_hi_nxt, hi_r, hi_nxt, code_r, code_nxt;
  logic [15:0] start_r, start_nxt, cnt_r, cnt_nxt, crc_r, crc_nxt;
  logic [RIW-1:0] wreg_r, wreg_nxt;
  logic        bcast_r, bcast_nxt;

  logic [1:0]  st_kind_r, st_kind_nxt, st_vd_r, st_vd_nxt;
  logic [7:0]  st_txb_r, st_txb_nxt;
  logic        st_txl_r, st_txl_nxt;
  logic [15:0] st_rv_r, st_rv_nxt;

  logic        out_vld_r, out_vld_nxt;
  logic [1:0]  out_kind_r, out_kind_nxt, out_vd_r, out_vd_nxt;
  logic [7:0]  out_txb_r, out_txb_nxt;
  logic        out_txl_r, out_txl_nxt;
  logic [15:0] out_rv_r, out_rv_nxt, out_err_r, out_err_nxt, out_rd_r, out_rd_nxt;

  logic        acc, out_free;
  logic [7:0]  rx_byte;
  logic [4:0]  reg_index;
  logic [15:0] reg_value;
  logic [5:0]  bound;
  logic [16:0] top;
  logic [17:0] rd_len;
  logic [CW-1:0] k_off;
  logic [7:0]  rd_sel;
  logic [7:0]  rep_byte;

  assign rx_byte   = in_tdata[7:0];
  assign reg_index = in_tdata[12:8];
  assign reg_value = in_tdata[28:13];
  assign in_tready = (state_r == mbrtu_pkg::S_IDLE);
  assign acc       = in_tvalid && in_tready;
  assign out_free  = !out_vld_r || out_tready;

  assign out_tvalid = out_vld_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_txl_r;
  assign out_tdata  = {6'd0, out_rd_r, out_err_r, out_vd_r, out_rv_r, out_txb_r};

  assign bound  = (riu_r < 6'(mbrtu_pkg::REG_COUNT)) ? riu_r : 6'(mbrtu_pkg::REG_COUNT);
  assign top    = {1'b0, start_r} + {1'b0, cnt_r};
  assign rd_len = {1'b0, cnt_r, 1'b0} + 18'd5;

  // reply byte selection
  assign k_off = pos_r - CW'(3);
  assign hr_ra = (state_r == mbrtu_pkg::S_REPLY) ?
                 RIW'(8'(start_r[5:0]) + 8'(k_off >> 1)) : RIW'(reg_index);
  assign hr_rd = hr_r[hr_ra];
  assign rd_sel = k_off[0] ? hr_rd[7:0] : hr_rd[15:8];

  always_comb begin
    rep_byte = 8'd0;
    if (pos_r == len_r - CW'(2)) begin
      rep_byte = crc_r[7:0];
    end else if (pos_r == len_r - CW'(1)) begin
      rep_byte = crc_r[15:8];
    end else begin
      case (pos_r)
        CW'(0): rep_byte = slave_r;
        CW'(1): rep_byte = (rtype_r == mbrtu_pkg::RT_EXC) ? (fn_r | mbrtu_pkg::EXC_FLAG) : fn_r;
        CW'(2): begin
          case (rtype_r)
            mbrtu_pkg::RT_EXC:  rep_byte = code_r;
            mbrtu_pkg::RT_READ: rep_byte = {cnt_r[6:0], 1'b0};
            default:            rep_byte = start_r[15:8];
          endcase
        end
        default: begin
          if (rtype_r == mbrtu_pkg::RT_READ) begin
            rep_byte = rd_sel;
          end else begin
            case (pos_r)
              CW'(3):  rep_byte = start_r[7:0];
              CW'(4):  rep_byte = cnt_r[15:8];
              default: rep_byte = cnt_r[7:0];
            endcase
          end
        end
      endcase
    end
  end

  always_comb begin
    state_nxt = state_r;  rtype_nxt = rtype_r;
    byte_cnt_nxt = byte_cnt_r;  nlen_nxt = nlen_r;
    rep_len_nxt = rep_len_r;  rep_pos_nxt = rep_pos_r;
    ptr_nxt = ptr_r;  ridx_nxt = ridx_r;  pos_nxt = pos_r;  len_nxt = len_r;
    ovf_nxt = ovf_r;  rv_vld_nxt = 1'b0;
    err_cnt_nxt = err_cnt_r;  rd_cnt_nxt = rd_cnt_r;
    slave_nxt = slave_r;  riu_nxt = riu_r;
    addr_nxt = addr_r;  fn_nxt = fn_r;  bc6_nxt = bc6_r;
    crc_lo_nxt = crc_lo_r;  crc_hi_nxt = crc_hi_r;  hi_nxt = hi_r;  code_nxt = code_r;
    start_nxt = start_r;  cnt_nxt = cnt_r;  crc_nxt = crc_r;
    wreg_nxt = wreg_r;  bcast_nxt = bcast_r;
    st_kind_nxt = st_kind_r;  st_vd_nxt = st_vd_r;  st_txb_nxt = st_txb_r;
    st_txl_nxt = st_txl_r;  st_rv_nxt = st_rv_r;
    out_vld_nxt = out_vld_r;  out_kind_nxt = out_kind_r;  out_vd_nxt = out_vd_r;
    out_txb_nxt = out_txb_r;  out_txl_nxt = out_txl_r;  out_rv_nxt = out_rv_r;
    out_err_nxt = out_err_r;  out_rd_nxt = out_rd_r;
    mem_we = 1'b0;  mem_wa = byte_cnt_r[AW-1:0];  mem_wd = rx_byte;
    mem_ra = rep_pos_r[AW-1:0];
    hr_we = 1'b0;  hr_wa = RIW'(reg_index);  hr_wd = reg_value;

    if (out_vld_r && out_tready) out_vld_nxt = 1'b0;

    if (cfg_wr_en) begin
      if (cfg_index == mbrtu_pkg::CFG_SLAVE) slave_nxt = cfg_wdata;
      else                                   riu_nxt   = cfg_wdata[5:0];
    end

    case (state_r)
      mbrtu_pkg::S_IDLE: begin
        if (acc) begin
          st_kind_nxt = mbrtu_pkg::KIND_VERDICT;  st_vd_nxt = mbrtu_pkg::VD_IGNORED;
          st_txb_nxt = 8'd0;  st_txl_nxt = 1'b0;  st_rv_nxt = 16'd0;
          case (in_tuser)
            mbrtu_pkg::MODE_RX: begin
              rep_len_nxt = '0;  rep_pos_nxt = '0;
              if (!ovf_r) begin
                if (byte_cnt_r >= CW'(mbrtu_pkg::FRAME_BYTES)) begin
                  ovf_nxt = 1'b1;
                end else begin
                  mem_we = 1'b1;
                  byte_cnt_nxt = byte_cnt_r + CW'(1);
                end
              end
            end
            mbrtu_pkg::MODE_GAP: begin
              nlen_nxt = byte_cnt_r;  byte_cnt_nxt = '0;  ovf_nxt = 1'b0;
              state_nxt = mbrtu_pkg::S_EMIT;
              if (ovf_r || (byte_cnt_r != '0 && byte_cnt_r < CW'(7))) begin
                err_cnt_nxt = err_cnt_r + 16'd1;
                st_vd_nxt = mbrtu_pkg::VD_ERROR;
              end else if (byte_cnt_r != '0) begin
                state_nxt = mbrtu_pkg::S_SCAN;
                ptr_nxt = '0;  crc_nxt = mbrtu_pkg::CRC_INIT;
              end
            end
            mbrtu_pkg::MODE_TX: begin
              if (rep_pos_r < rep_len_r) state_nxt = mbrtu_pkg::S_TXRD;
            end
            mbrtu_pkg::MODE_HRD: begin
              st_kind_nxt = mbrtu_pkg::KIND_HOST;
              st_rv_nxt = (32'(reg_index) < mbrtu_pkg::REG_COUNT) ? hr_rd : 16'd0;
              state_nxt = mbrtu_pkg::S_EMIT;
            end
            mbrtu_pkg::MODE_HWR: begin
              hr_we = (32'(reg_index) < mbrtu_pkg::REG_COUNT);
            end
            default: ;
          endcase
        end
      end

      mbrtu_pkg::S_TXRD: begin
        st_kind_nxt = mbrtu_pkg::KIND_TX;
        st_txb_nxt = rdata_r;
        if (rep_pos_r + CW'(1) >= rep_len_r) begin
          st_txl_nxt = 1'b1;  rep_len_nxt = '0;  rep_pos_nxt = '0;
        end else begin
          rep_pos_nxt = rep_pos_r + CW'(1);
        end
        state_nxt = mbrtu_pkg::S_EMIT;
      end

      mbrtu_pkg::S_SCAN: begin
        mem_ra = ptr_r[AW-1:0];
        if (ptr_r < nlen_r) begin
          rv_vld_nxt = 1'b1;  ridx_nxt = ptr_r;  ptr_nxt = ptr_r + CW'(1);
        end
        if (rv_vld_r) begin
          case (ridx_r)
            CW'(0): addr_nxt = rdata_r;
            CW'(1): fn_nxt = rdata_r;
            CW'(2): start_nxt[15:8] = rdata_r;
            CW'(3): start_nxt[7:0] = rdata_r;
            CW'(4): cnt_nxt[15:8] = rdata_r;
            CW'(5): cnt_nxt[7:0] = rdata_r;
            CW'(6): bc6_nxt = rdata_r;
            default: ;
          endcase
          if (ridx_r < nlen_r - CW'(2))      crc_nxt = mbrtu_pkg::crc16_byte(crc_r, rdata_r);
          else if (ridx_r == nlen_r - CW'(2)) crc_lo_nxt = rdata_r;
          else begin
            crc_hi_nxt = rdata_r;
            state_nxt = mbrtu_pkg::S_CHECK;
          end
        end
      end

      mbrtu_pkg::S_CHECK: begin
        bcast_nxt = (addr_r == 8'd0);
        state_nxt = mbrtu_pkg::S_EMIT;
        rtype_nxt = mbrtu_pkg::RT_EXC;  len_nxt = CW'(5);
        pos_nxt = '0;  crc_nxt = mbrtu_pkg::CRC_INIT;
        code_nxt = mbrtu_pkg::EXC_FUNC;
        if (addr_r != slave_r && addr_r != 8'd0) begin
          st_vd_nxt = mbrtu_pkg::VD_IGNORED;
        end else if (crc_lo_r != crc_r[7:0] || crc_hi_r != crc_r[15:8]) begin
          err_cnt_nxt = err_cnt_r + 16'd1;  st_vd_nxt = mbrtu_pkg::VD_ERROR;
        end else begin
          st_vd_nxt = mbrtu_pkg::VD_ERROR;
          if (fn_r == mbrtu_pkg::FN_READ && addr_r != 8'd0) begin
            if (start_r >= 16'(bound)) code_nxt = mbrtu_pkg::EXC_ADDR;
            else if (cnt_r == 16'd0 || top > 17'(bound) ||
                     rd_len > 18'(mbrtu_pkg::FRAME_BYTES)) code_nxt = mbrtu_pkg::EXC_DATA;
            else begin
              code_nxt = 8'd0;  rtype_nxt = mbrtu_pkg::RT_READ;
              len_nxt = CW'(rd_len);  rd_cnt_nxt = rd_cnt_r + 16'd1;
              st_vd_nxt = mbrtu_pkg::VD_REPLY;
            end
          end else if (fn_r == mbrtu_pkg::FN_WR1) begin
            if (start_r >= 16'(bound)) code_nxt = mbrtu_pkg::EXC_ADDR;
            else begin
              code_nxt = 8'd0;
              hr_we = 1'b1;  hr_wa = RIW'(start_r);  hr_wd = cnt_r;
              rtype_nxt = mbrtu_pkg::RT_ECHO;  len_nxt = CW'(8);
              st_vd_nxt = (addr_r == 8'd0) ? mbrtu_pkg::VD_BCAST : mbrtu_pkg::VD_REPLY;
            end
          end else if (fn_r == mbrtu_pkg::FN_WRN) begin
            if (16'(bc6_r) + 16'd9 != 16'(nlen_r)) code_nxt = 8'd0;
            else if (start_r >= 16'(bound)) code_nxt = mbrtu_pkg::EXC_ADDR;
            else if (cnt_r == 16'd0 || top > 17'(bound) ||
                     {9'd0, bc6_r} != {cnt_r, 1'b0}) code_nxt = mbrtu_pkg::EXC_DATA;
            else begin
              code_nxt = 8'd0;  rtype_nxt = mbrtu_pkg::RT_ECHO;  len_nxt = CW'(8);
              st_vd_nxt = (addr_r == 8'd0) ? mbrtu_pkg::VD_BCAST : mbrtu_pkg::VD_REPLY;
            end
          end
          if (st_vd_nxt == mbrtu_pkg::VD_ERROR) err_cnt_nxt = err_cnt_r + 16'd1;
          if (st_vd_nxt == mbrtu_pkg::VD_ERROR && code_nxt != 8'd0 && addr_r != 8'd0)
            state_nxt = mbrtu_pkg::S_REPLY;
          else if (st_vd_nxt != mbrtu_pkg::VD_ERROR && fn_r == mbrtu_pkg::FN_WRN) begin
            state_nxt = mbrtu_pkg::S_COPY;
            ptr_nxt = CW'(7);  wreg_nxt = RIW'(start_r);
          end else if (st_vd_nxt == mbrtu_pkg::VD_REPLY)
            state_nxt = mbrtu_pkg::S_REPLY;
        end
      end

      mbrtu_pkg::S_COPY: begin
        mem_ra = ptr_r[AW-1:0];
        if (ptr_r < nlen_r - CW'(2)) begin
          rv_vld_nxt = 1'b1;  ridx_nxt = ptr_r;  ptr_nxt = ptr_r + CW'(1);
        end
        if (rv_vld_r) begin
          if (ridx_r[0]) hi_nxt = rdata_r;
          else begin
            hr_we = 1'b1;  hr_wa = wreg_r;  hr_wd = {hi_r, rdata_r};
            wreg_nxt = wreg_r + RIW'(1);
          end
          if (ridx_r == nlen_r - CW'(3))
            state_nxt = bcast_r ? mbrtu_pkg::S_EMIT : mbrtu_pkg::S_REPLY;
        end
      end

      mbrtu_pkg::S_REPLY: begin
        mem_we = 1'b1;  mem_wa = pos_r[AW-1:0];  mem_wd = rep_byte;
        if (pos_r < len_r - CW'(2)) crc_nxt = mbrtu_pkg::crc16_byte(crc_r, rep_byte);
        pos_nxt = pos_r + CW'(1);
        if (pos_r == len_r - CW'(1)) begin
          rep_len_nxt = len_r;  rep_pos_nxt = '0;
          state_nxt = mbrtu_pkg::S_EMIT;
        end
      end

      mbrtu_pkg::S_EMIT: begin
        if (out_free) begin
          out_vld_nxt = 1'b1;
          out_kind_nxt = st_kind_r;  out_vd_nxt = st_vd_r;  out_txb_nxt = st_txb_r;
          out_txl_nxt = st_txl_r;    out_rv_nxt = st_rv_r;
          out_err_nxt = err_cnt_r;   out_rd_nxt = rd_cnt_r;
          state_nxt = mbrtu_pkg::S_IDLE;
        end
      end

      default: state_nxt = mbrtu_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    rdata_r <= mem[mem_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < mbrtu_pkg::REG_COUNT; i++) hr_r[i] <= 16'd0;
    end else if (hr_we) begin
      hr_r[hr_wa] <= hr_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mbrtu_pkg::S_IDLE;
      byte_cnt_r <= '0;  ovf_r <= 1'b0;  rep_len_r <= '0;  rep_pos_r <= '0;
      err_cnt_r <= 16'd0;  rd_cnt_r <= 16'd0;
      slave_r <= 8'd1;  riu_r <= 6'd32;
      rv_vld_r <= 1'b0;  out_vld_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      byte_cnt_r <= byte_cnt_nxt;  ovf_r <= ovf_nxt;
      rep_len_r <= rep_len_nxt;  rep_pos_r <= rep_pos_nxt;
      err_cnt_r <= err_cnt_nxt;  rd_cnt_r <= rd_cnt_nxt;
      slave_r <= slave_nxt;  riu_r <= riu_nxt;
      rv_vld_r <= rv_vld_nxt;  out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rtype_r <= rtype_nxt;  nlen_r <= nlen_nxt;
    ptr_r <= ptr_nxt;  ridx_r <= ridx_nxt;  pos_r <= pos_nxt;  len_r <= len_nxt;
    addr_r <= addr_nxt;  fn_r <= fn_nxt;  bc6_r <= bc6_nxt;
    crc_lo_r <= crc_lo_nxt;  crc_hi_r <= crc_hi_nxt;  hi_r <= hi_nxt;  code_r <= code_nxt;
    start_r <= start_nxt;  cnt_r <= cnt_nxt;  crc_r <= crc_nxt;
    wreg_r <= wreg_nxt;  bcast_r <= bcast_nxt;
    st_kind_r <= st_kind_nxt;  st_vd_r <= st_vd_nxt;  st_txb_r <= st_txb_nxt;
    st_txl_r <= st_txl_nxt;  st_rv_r <= st_rv_nxt;
    out_kind_r <= out_kind_nxt;  out_vd_r <= out_vd_nxt;  out_txb_r <= out_txb_nxt;
    out_txl_r <= out_txl_nxt;  out_rv_r <= out_rv_nxt;
    out_err_r <= out_err_nxt;  out_rd_r <= out_rd_nxt;
  end

  a_rep_pos: assert property (@(posedge clk) disable iff (!rst_n)
    rep_pos_r <= rep_len_r) else $error("reply position past reply length");

  a_byte_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    byte_cnt_r <= CW'(mbrtu_pkg::FRAME_BYTES)) else $error("frame count past capacity");

  a_last_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != mbrtu_pkg::KIND_TX |-> !out_tlast)
    else $error("tlast on a non-transmit word");

  a_emit_busy: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == mbrtu_pkg::S_EMIT && !out_free |=> state_r == mbrtu_pkg::S_EMIT)
    else $error("result dropped while output busy");

endmodule
`default_nettype wire
